### src/sdsq_pkg.sv
// Shared types, codes and helper functions for the SD card SPI sequencer.
package sdsq_pkg;

  typedef enum logic [12:0] {
    PH_IDLE   = 13'b0_0000_0000_0001,
    PH_DUMMY  = 13'b0_0000_0000_0010,
    PH_CMD0   = 13'b0_0000_0000_0100,
    PH_CMD8   = 13'b0_0000_0000_1000,
    PH_CMD55  = 13'b0_0000_0001_0000,
    PH_ACMD41 = 13'b0_0000_0010_0000,
    PH_CMD1   = 13'b0_0000_0100_0000,
    PH_CMD59  = 13'b0_0000_1000_0000,
    PH_CMD16  = 13'b0_0001_0000_0000,
    PH_READY  = 13'b0_0010_0000_0000,
    PH_CMD24  = 13'b0_0100_0000_0000,
    PH_WRITE  = 13'b0_1000_0000_0000,
    PH_FAILED = 13'b1_0000_0000_0000
  } phase_t;

  localparam logic [1:0] EV_START = 2'd0;
  localparam logic [1:0] EV_DONE  = 2'd1;
  localparam logic [1:0] EV_WRITE = 2'd2;

  localparam logic [1:0] SK_NONE  = 2'd0;
  localparam logic [1:0] SK_DUMMY = 2'd1;
  localparam logic [1:0] SK_CMD   = 2'd2;
  localparam logic [1:0] SK_DATA  = 2'd3;

  localparam logic [1:0] ST_BUSY  = 2'd0;
  localparam logic [1:0] ST_READY = 2'd1;
  localparam logic [1:0] ST_IFAIL = 2'd2;
  localparam logic [1:0] ST_WFAIL = 2'd3;

  localparam logic [7:0] R1_OK      = 8'h00;
  localparam logic [7:0] R1_IDLE    = 8'h01;
  localparam logic [7:0] R1_ILLEGAL = 8'h04;
  localparam logic [7:0] R1_OLDCARD = 8'h05;

  localparam logic [0:0] REG_RETRY_LIMIT = 1'd0;
  localparam logic [0:0] REG_BLOCK_LEN   = 1'd1;

  localparam logic [15:0] RetryLimitRst = 16'd1000;
  localparam logic [9:0]  BlockLenRst   = 10'd512;

  localparam logic [31:0] CMD8_ARG    = 32'h0000_01AA;
  localparam logic [31:0] ACMD41_ARG  = 32'h4000_0000;
  localparam logic [7:0]  DATA_TOKEN  = 8'hFE;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  resp;
    logic [31:0] block_addr;
  } req_t;

  typedef struct packed {
    logic [1:0]  send_kind;
    logic [7:0]  cmd_byte;
    logic [31:0] cmd_arg;
    logic [7:0]  cmd_crc;
    logic [2:0]  resp_len;
    logic [1:0]  status;
  } res_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] retry_count;
    logic [31:0] pending_addr;
  } seq_state_t;

  typedef struct packed {
    logic [15:0] retry_limit;
    logic [9:0]  block_len;
  } cfg_t;

  function automatic res_t frame_res(logic [5:0] idx, logic [31:0] arg, logic [7:0] crc,
                                     logic [2:0] len);
    res_t r;
    r.send_kind = SK_CMD;
    r.cmd_byte  = {2'b01, idx};
    r.cmd_arg   = arg;
    r.cmd_crc   = crc;
    r.resp_len  = len;
    r.status    = ST_BUSY;
    return r;
  endfunction

  function automatic res_t quiet_res(logic [1:0] st);
    res_t r;
    r.send_kind = SK_NONE;
    r.cmd_byte  = 8'd0;
    r.cmd_arg   = 32'd0;
    r.cmd_crc   = 8'd0;
    r.resp_len  = 3'd0;
    r.status    = st;
    return r;
  endfunction

  function automatic logic [1:0] phase_status(phase_t ph);
    logic [1:0] st;
    st = ST_BUSY;
    if (ph == PH_READY) st = ST_READY;
    if (ph == PH_FAILED) st = ST_IFAIL;
    return st;
  endfunction

endpackage

### src/sdsq_intf.sv
// Request, result and register-write channel interfaces.
interface sdsq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  resp;
  logic [31:0] block_addr;
  modport source (output valid, cmd, resp, block_addr, input ready);
  modport sink   (input valid, cmd, resp, block_addr, output ready);
endinterface

interface sdsq_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  send_kind;
  logic [7:0]  cmd_byte;
  logic [31:0] cmd_arg;
  logic [7:0]  cmd_crc;
  logic [2:0]  resp_len;
  logic [1:0]  status;
  modport source (output valid, send_kind, cmd_byte, cmd_arg, cmd_crc, resp_len, status,
                  input ready);
  modport sink   (input valid, send_kind, cmd_byte, cmd_arg, cmd_crc, resp_len, status,
                  output ready);
endinterface

interface sdsq_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/sdsq_cfg_regs.sv
// Configuration registers: retry limit and CMD16 block length.
module sdsq_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [0:0]         wr_index,
  input  logic [15:0]        wr_data,
  output sdsq_pkg::cfg_t     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.retry_limit <= sdsq_pkg::RetryLimitRst;
      cfg.block_len   <= sdsq_pkg::BlockLenRst;
    end else if (wr_en) begin
      unique case (wr_index)
        sdsq_pkg::REG_RETRY_LIMIT: cfg.retry_limit <= wr_data;
        sdsq_pkg::REG_BLOCK_LEN:   cfg.block_len   <= wr_data[9:0];
        default: ;
      endcase
    end
  end

endmodule

### src/sdsq_step.sv
// Next-state and next-frame logic for one event.
module sdsq_step (
  input  sdsq_pkg::seq_state_t state,
  input  sdsq_pkg::req_t       req,
  input  sdsq_pkg::cfg_t       cfg,
  output sdsq_pkg::seq_state_t state_next,
  output sdsq_pkg::res_t       res
);

  logic retry_out;
  logic [15:0] retry_inc;

  assign retry_out = state.retry_count >= cfg.retry_limit;
  assign retry_inc = state.retry_count + 16'd1;

  always_comb begin
    state_next = state;
    res        = sdsq_pkg::quiet_res(sdsq_pkg::phase_status(state.phase));
    priority if (req.cmd == sdsq_pkg::EV_START) begin
      state_next.phase       = sdsq_pkg::PH_DUMMY;
      state_next.retry_count = 16'd0;
      res                    = sdsq_pkg::quiet_res(sdsq_pkg::ST_BUSY);
      res.send_kind          = sdsq_pkg::SK_DUMMY;
    end else if (req.cmd == sdsq_pkg::EV_DONE) begin
      unique case (state.phase)
        sdsq_pkg::PH_DUMMY: begin
          state_next.phase = sdsq_pkg::PH_CMD0;
          res = sdsq_pkg::frame_res(6'd0, 32'd0, 8'h95, 3'd1);
        end
        sdsq_pkg::PH_CMD0: begin
          if (req.resp == sdsq_pkg::R1_IDLE) begin
            state_next.phase = sdsq_pkg::PH_CMD8;
            res = sdsq_pkg::frame_res(6'd8, sdsq_pkg::CMD8_ARG, 8'h87, 3'd5);
          end else begin
            state_next.phase = sdsq_pkg::PH_FAILED;
            res = sdsq_pkg::quiet_res(sdsq_pkg::ST_IFAIL);
          end
        end
        sdsq_pkg::PH_CMD8: begin
          if (req.resp == sdsq_pkg::R1_IDLE) begin
            state_next.phase = sdsq_pkg::PH_CMD55;
            res = sdsq_pkg::frame_res(6'd55, 32'd0, 8'h65, 3'd1);
          end else begin
            state_next.phase = sdsq_pkg::PH_FAILED;
            res = sdsq_pkg::quiet_res(sdsq_pkg::ST_IFAIL);
          end
        end
        sdsq_pkg::PH_CMD55: begin
          priority if (req.resp == sdsq_pkg::R1_OLDCARD) begin
            state_next.phase = sdsq_pkg::PH_CMD1;
            res = sdsq_pkg::frame_res(6'd1, 32'd0, 8'hF9, 3'd1);
          end else if (req.resp == sdsq_pkg::R1_IDLE) begin
            state_next.phase = sdsq_pkg::PH_ACMD41;
            res = sdsq_pkg::frame_res(6'd41, sdsq_pkg::ACMD41_ARG, 8'h77, 3'd1);
          end else begin
            state_next.phase = sdsq_pkg::PH_FAILED;
            res = sdsq_pkg::quiet_res(sdsq_pkg::ST_IFAIL);
          end
        end
        sdsq_pkg::PH_ACMD41, sdsq_pkg::PH_CMD1: begin
          priority if (req.resp == sdsq_pkg::R1_OK) begin
            state_next.phase = sdsq_pkg::PH_CMD59;
            res = sdsq_pkg::frame_res(6'd59, 32'd0, 8'hFF, 3'd1);
          end else if (req.resp == sdsq_pkg::R1_IDLE && !retry_out) begin
            state_next.retry_count = retry_inc;
            if (state.phase == sdsq_pkg::PH_CMD1) begin
              state_next.phase = sdsq_pkg::PH_CMD1;
              res = sdsq_pkg::frame_res(6'd1, 32'd0, 8'hF9, 3'd1);
            end else begin
              state_next.phase = sdsq_pkg::PH_CMD55;
              res = sdsq_pkg::frame_res(6'd55, 32'd0, 8'h65, 3'd1);
            end
          end else begin
            state_next.phase = sdsq_pkg::PH_FAILED;
            res = sdsq_pkg::quiet_res(sdsq_pkg::ST_IFAIL);
          end
        end
        sdsq_pkg::PH_CMD59: begin
          state_next.phase = sdsq_pkg::PH_CMD16;
          res = sdsq_pkg::frame_res(6'd16, {22'd0, cfg.block_len}, 8'hFF, 3'd1);
        end
        sdsq_pkg::PH_CMD16: begin
          if (req.resp == sdsq_pkg::R1_OK || req.resp == sdsq_pkg::R1_IDLE ||
              req.resp == sdsq_pkg::R1_ILLEGAL) begin
            state_next.phase = sdsq_pkg::PH_READY;
            res = sdsq_pkg::quiet_res(sdsq_pkg::ST_READY);
          end else begin
            state_next.phase = sdsq_pkg::PH_FAILED;
            res = sdsq_pkg::quiet_res(sdsq_pkg::ST_IFAIL);
          end
        end
        sdsq_pkg::PH_CMD24: begin
          if (req.resp == sdsq_pkg::R1_OK) begin
            state_next.phase = sdsq_pkg::PH_WRITE;
            res           = sdsq_pkg::quiet_res(sdsq_pkg::ST_BUSY);
            res.send_kind = sdsq_pkg::SK_DATA;
            res.cmd_byte  = sdsq_pkg::DATA_TOKEN;
            res.cmd_arg   = state.pending_addr;
            res.resp_len  = 3'd1;
          end else begin
            state_next.phase = sdsq_pkg::PH_READY;
            res = sdsq_pkg::quiet_res(sdsq_pkg::ST_WFAIL);
          end
        end
        sdsq_pkg::PH_WRITE: begin
          state_next.phase = sdsq_pkg::PH_READY;
          res = sdsq_pkg::quiet_res(sdsq_pkg::ST_READY);
        end
        default: ;
      endcase
    end else if (req.cmd == sdsq_pkg::EV_WRITE && state.phase == sdsq_pkg::PH_READY) begin
      state_next.phase        = sdsq_pkg::PH_CMD24;
      state_next.pending_addr = req.block_addr;
      res = sdsq_pkg::frame_res(6'd24, req.block_addr, 8'h00, 3'd1);
    end else begin
      // ignored event: quiet result with the phase status
    end
  end

endmodule

### src/sd_spi_init_and_write_sequencer_core.sv
// Top level of the SD card SPI-mode init and block-write sequencer.
// Each event request yields one result request, the frame to send next and a status.
// An event passes an input register and then a result register before its result is shown;
// one event is taken every cycle while the result side keeps up, and the combinational
// phase update between the two registers sets that rate.
// Register writes are taken every cycle and belong in quiet periods only.
module sd_spi_init_and_write_sequencer_core (
  input logic       clk,
  input logic       rst,
  sdsq_req_if.sink  req,
  sdsq_res_if.source rsp,
  sdsq_cfg_if.sink  cfg
);

  sdsq_pkg::cfg_t       cfg_q;
  sdsq_pkg::seq_state_t state;
  sdsq_pkg::seq_state_t state_next;
  sdsq_pkg::req_t       in_q;
  sdsq_pkg::res_t       res_next;
  sdsq_pkg::res_t       res_q;
  logic                 in_valid;
  logic                 out_valid;
  logic                 advance;

  assign cfg.ready = 1'b1;

  sdsq_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_q)
  );

  sdsq_step u_step (
    .state      (state),
    .req        (in_q),
    .cfg        (cfg_q),
    .state_next (state_next),
    .res        (res_next)
  );

  assign advance   = !out_valid || rsp.ready;
  assign req.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_q.cmd        <= req.cmd;
      in_q.resp       <= req.resp;
      in_q.block_addr <= req.block_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid          <= 1'b0;
      state.phase        <= sdsq_pkg::PH_IDLE;
      state.retry_count  <= 16'd0;
      state.pending_addr <= 32'd0;
    end else if (advance) begin
      out_valid <= in_valid;
      if (in_valid) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      res_q <= res_next;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.send_kind = res_q.send_kind;
  assign rsp.cmd_byte  = res_q.cmd_byte;
  assign rsp.cmd_arg   = res_q.cmd_arg;
  assign rsp.cmd_crc   = res_q.cmd_crc;
  assign rsp.resp_len  = res_q.resp_len;
  assign rsp.status    = res_q.status;

endmodule

### src/sdsq_checker.sv
// Port-level checks on the sequencer, bound to the top level.
module sdsq_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  send_kind,
  input logic [7:0]  cmd_byte,
  input logic [31:0] cmd_arg,
  input logic [7:0]  cmd_crc,
  input logic [2:0]  resp_len,
  input logic [1:0]  status
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result request dropped while stalled");

  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result request shown straight after reset");

  a_quiet_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (send_kind == sdsq_pkg::SK_NONE || send_kind == sdsq_pkg::SK_DUMMY)
      |-> cmd_byte == 8'd0 && cmd_arg == 32'd0 && cmd_crc == 8'd0 && resp_len == 3'd0)
    else $error("frame fields set with nothing to send");

  a_cmd_byte: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && send_kind == sdsq_pkg::SK_CMD |-> cmd_byte[7:6] == 2'b01 && resp_len != 3'd0)
    else $error("malformed command frame");

  a_send_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && send_kind != sdsq_pkg::SK_NONE |-> status == sdsq_pkg::ST_BUSY)
    else $error("status not busy while sending");

endmodule

bind sd_spi_init_and_write_sequencer_core sdsq_checker u_sdsq_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .send_kind (rsp.send_kind),
  .cmd_byte  (rsp.cmd_byte),
  .cmd_arg   (rsp.cmd_arg),
  .cmd_crc   (rsp.cmd_crc),
  .resp_len  (rsp.resp_len),
  .status    (rsp.status)
);

### sim/testbench.sv
// Self-checking testbench for the SD card SPI init and block-write sequencer.
module testbench;

  localparam logic [5:0] IDX_CMD0   = 6'd0;
  localparam logic [5:0] IDX_CMD1   = 6'd1;
  localparam logic [5:0] IDX_CMD8   = 6'd8;
  localparam logic [5:0] IDX_CMD16  = 6'd16;
  localparam logic [5:0] IDX_CMD24  = 6'd24;
  localparam logic [5:0] IDX_ACMD41 = 6'd41;
  localparam logic [5:0] IDX_CMD55  = 6'd55;
  localparam logic [5:0] IDX_CMD59  = 6'd59;

  localparam logic [7:0] CRC_CMD0   = 8'h95;
  localparam logic [7:0] CRC_CMD8   = 8'h87;
  localparam logic [7:0] CRC_CMD55  = 8'h65;
  localparam logic [7:0] CRC_ACMD41 = 8'h77;
  localparam logic [7:0] CRC_CMD1   = 8'hF9;
  localparam logic [7:0] CRC_NONE   = 8'hFF;
  localparam logic [7:0] CRC_CMD24  = 8'h00;

  localparam logic [1:0] EV_SPARE = 2'd3;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE      = 8;

  logic clk;
  logic rst;

  sdsq_req_if req_ch ();
  sdsq_res_if rsp_ch ();
  sdsq_cfg_if cfg_ch ();

  sd_spi_init_and_write_sequencer_core u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  sdsq_pkg::phase_t card_phase;
  logic [15:0] retries_used;
  logic [31:0] write_addr;
  logic [15:0] retry_cap;
  logic [9:0]  blk_len;

  sdsq_pkg::req_t pending_reqs[$];
  sdsq_pkg::res_t frames_due[$];
  sdsq_pkg::req_t next_req;
  sdsq_pkg::res_t exp_frame;

  int issued      = 0;
  int errors      = 0;
  int idle_cycles = 0;
  int gap_left    = 0;
  int stall_left  = 0;
  int wait_draw   = 0;
  bit calm        = 1'b0;

  function automatic sdsq_pkg::res_t cmd_res(logic [5:0] idx, logic [31:0] arg,
                                             logic [7:0] crc, logic [2:0] len);
    return {sdsq_pkg::SK_CMD, 2'b01, idx, arg, crc, len, sdsq_pkg::ST_BUSY};
  endfunction

  function automatic sdsq_pkg::res_t bare_res(logic [1:0] kind, logic [1:0] st);
    return {kind, 51'd0, st};
  endfunction

  function automatic logic [1:0] card_status();
    if (card_phase == sdsq_pkg::PH_READY) return sdsq_pkg::ST_READY;
    if (card_phase == sdsq_pkg::PH_FAILED) return sdsq_pkg::ST_IFAIL;
    return sdsq_pkg::ST_BUSY;
  endfunction

  function automatic int draw_wait();
    if (calm) return 0;
    return $urandom_range(0, 16);
  endfunction

  function automatic sdsq_pkg::res_t predict_frame(sdsq_pkg::req_t rq);
    sdsq_pkg::res_t o;
    logic failed;
    failed = 1'b0;
    o = bare_res(sdsq_pkg::SK_NONE, card_status());
    case (rq.cmd)
      sdsq_pkg::EV_START: begin
        card_phase = sdsq_pkg::PH_DUMMY;
        retries_used = 16'd0;
        o = bare_res(sdsq_pkg::SK_DUMMY, sdsq_pkg::ST_BUSY);
      end
      sdsq_pkg::EV_DONE: begin
        case (card_phase)
          sdsq_pkg::PH_DUMMY: begin
            o = cmd_res(IDX_CMD0, 32'd0, CRC_CMD0, 3'd1);
            card_phase = sdsq_pkg::PH_CMD0;
          end
          sdsq_pkg::PH_CMD0: begin
            if (rq.resp != sdsq_pkg::R1_IDLE) failed = 1'b1;
            else begin
              o = cmd_res(IDX_CMD8, sdsq_pkg::CMD8_ARG, CRC_CMD8, 3'd5);
              card_phase = sdsq_pkg::PH_CMD8;
            end
          end
          sdsq_pkg::PH_CMD8: begin
            if (rq.resp != sdsq_pkg::R1_IDLE) failed = 1'b1;
            else begin
              o = cmd_res(IDX_CMD55, 32'd0, CRC_CMD55, 3'd1);
              card_phase = sdsq_pkg::PH_CMD55;
            end
          end
          sdsq_pkg::PH_CMD55: begin
            if (rq.resp == sdsq_pkg::R1_OLDCARD) begin
              o = cmd_res(IDX_CMD1, 32'd0, CRC_CMD1, 3'd1);
              card_phase = sdsq_pkg::PH_CMD1;
            end else if (rq.resp != sdsq_pkg::R1_IDLE) failed = 1'b1;
            else begin
              o = cmd_res(IDX_ACMD41, sdsq_pkg::ACMD41_ARG, CRC_ACMD41, 3'd1);
              card_phase = sdsq_pkg::PH_ACMD41;
            end
          end
          sdsq_pkg::PH_ACMD41, sdsq_pkg::PH_CMD1: begin
            if (rq.resp == sdsq_pkg::R1_OK) begin
              o = cmd_res(IDX_CMD59, 32'd0, CRC_NONE, 3'd1);
              card_phase = sdsq_pkg::PH_CMD59;
            end else if (rq.resp != sdsq_pkg::R1_IDLE || retries_used >= retry_cap) begin
              failed = 1'b1;
            end else begin
              retries_used = retries_used + 16'd1;
              if (card_phase == sdsq_pkg::PH_CMD1) begin
                o = cmd_res(IDX_CMD1, 32'd0, CRC_CMD1, 3'd1);
              end else begin
                o = cmd_res(IDX_CMD55, 32'd0, CRC_CMD55, 3'd1);
                card_phase = sdsq_pkg::PH_CMD55;
              end
            end
          end
          sdsq_pkg::PH_CMD59: begin
            o = cmd_res(IDX_CMD16, {22'd0, blk_len}, CRC_NONE, 3'd1);
            card_phase = sdsq_pkg::PH_CMD16;
          end
          sdsq_pkg::PH_CMD16: begin
            if (rq.resp == sdsq_pkg::R1_OK || rq.resp == sdsq_pkg::R1_IDLE ||
                rq.resp == sdsq_pkg::R1_ILLEGAL) begin
              card_phase = sdsq_pkg::PH_READY;
              o = bare_res(sdsq_pkg::SK_NONE, sdsq_pkg::ST_READY);
            end else failed = 1'b1;
          end
          sdsq_pkg::PH_CMD24: begin
            if (rq.resp != sdsq_pkg::R1_OK) begin
              card_phase = sdsq_pkg::PH_READY;
              o = bare_res(sdsq_pkg::SK_NONE, sdsq_pkg::ST_WFAIL);
            end else begin
              card_phase = sdsq_pkg::PH_WRITE;
              o = {sdsq_pkg::SK_DATA, sdsq_pkg::DATA_TOKEN, write_addr, 8'd0, 3'd1,
                   sdsq_pkg::ST_BUSY};
            end
          end
          sdsq_pkg::PH_WRITE: begin
            card_phase = sdsq_pkg::PH_READY;
            o = bare_res(sdsq_pkg::SK_NONE, sdsq_pkg::ST_READY);
          end
          default: ;
        endcase
      end
      sdsq_pkg::EV_WRITE: begin
        if (card_phase == sdsq_pkg::PH_READY) begin
          write_addr = rq.block_addr;
          o = cmd_res(IDX_CMD24, rq.block_addr, CRC_CMD24, 3'd1);
          card_phase = sdsq_pkg::PH_CMD24;
        end
      end
      default: ;
    endcase
    if (failed) begin
      card_phase = sdsq_pkg::PH_FAILED;
      o = bare_res(sdsq_pkg::SK_NONE, sdsq_pkg::ST_IFAIL);
    end
    return o;
  endfunction

  task automatic push_item(logic [1:0] c, logic [7:0] r, logic [31:0] a);
    pending_reqs.push_back({c, r, a});
    issued++;
  endtask

  // card answer, now and then corrupted or preceded by a stray request
  task automatic answer(logic [7:0] r);
    int n;
    n = $urandom_range(0, 39);
    if (n == 0) push_item(2'($urandom_range(0, 3)), 8'($urandom), $urandom);
    else if (n == 1) r = 8'($urandom);
    push_item(sdsq_pkg::EV_DONE, r, $urandom);
  endtask

  task automatic gen_init(bit old_card, int reps);
    int pick;
    push_item(sdsq_pkg::EV_START, 8'($urandom), $urandom);
    answer(8'($urandom));
    answer(sdsq_pkg::R1_IDLE);
    answer(sdsq_pkg::R1_IDLE);
    if (old_card) begin
      answer(sdsq_pkg::R1_OLDCARD);
      repeat (reps) answer(sdsq_pkg::R1_IDLE);
    end else begin
      answer(sdsq_pkg::R1_IDLE);
      repeat (reps) begin
        answer(sdsq_pkg::R1_IDLE);
        answer(sdsq_pkg::R1_IDLE);
      end
    end
    answer(sdsq_pkg::R1_OK);
    answer(8'($urandom));
    pick = $urandom_range(0, 9);
    if (pick < 3) answer(sdsq_pkg::R1_OK);
    else if (pick < 5) answer(sdsq_pkg::R1_IDLE);
    else if (pick < 7) answer(sdsq_pkg::R1_ILLEGAL);
    else if (pick == 7) answer(8'($urandom));
    else answer(sdsq_pkg::R1_OK);
  endtask

  task automatic gen_writes(int n);
    repeat (n) begin
      push_item(sdsq_pkg::EV_WRITE, 8'($urandom), $urandom);
      if ($urandom_range(0, 5) == 0) answer(8'($urandom_range(1, 255)));
      else answer(sdsq_pkg::R1_OK);
      answer(8'($urandom));
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_ch.valid || frames_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == sdsq_pkg::REG_RETRY_LIMIT) retry_cap = val;
    else blk_len = val[9:0];
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // event request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready)
        frames_due.push_back(predict_frame({req_ch.cmd, req_ch.resp, req_ch.block_addr}));
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left > 0) begin
          req_ch.valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_reqs.size() != 0) begin
          next_req = pending_reqs.pop_front();
          req_ch.valid      <= 1'b1;
          req_ch.cmd        <= next_req.cmd;
          req_ch.resp       <= next_req.resp;
          req_ch.block_addr <= next_req.block_addr;
          gap_left <= draw_wait();
        end else req_ch.valid <= 1'b0;
      end
    end
  end

  // result request monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (rsp_ch.valid && rsp_ch.ready) begin
      if (frames_due.size() == 0) begin
        $error("unexpected result request, nothing expected");
        errors++;
      end else begin
        exp_frame = frames_due.pop_front();
        if (rsp_ch.send_kind !== exp_frame.send_kind) begin
          $error("send_kind: expected %0h, got %0h", exp_frame.send_kind, rsp_ch.send_kind);
          errors++;
        end
        if (rsp_ch.cmd_byte !== exp_frame.cmd_byte) begin
          $error("cmd_byte: expected %0h, got %0h", exp_frame.cmd_byte, rsp_ch.cmd_byte);
          errors++;
        end
        if (rsp_ch.cmd_arg !== exp_frame.cmd_arg) begin
          $error("cmd_arg: expected %0h, got %0h", exp_frame.cmd_arg, rsp_ch.cmd_arg);
          errors++;
        end
        if (rsp_ch.cmd_crc !== exp_frame.cmd_crc) begin
          $error("cmd_crc: expected %0h, got %0h", exp_frame.cmd_crc, rsp_ch.cmd_crc);
          errors++;
        end
        if (rsp_ch.resp_len !== exp_frame.resp_len) begin
          $error("resp_len: expected %0h, got %0h", exp_frame.resp_len, rsp_ch.resp_len);
          errors++;
        end
        if (rsp_ch.status !== exp_frame.status) begin
          $error("status: expected %0h, got %0h", exp_frame.status, rsp_ch.status);
          errors++;
        end
      end
      wait_draw = draw_wait();
      stall_left <= wait_draw;
      rsp_ch.ready <= (wait_draw == 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_ch.ready <= (stall_left == 1);
    end else rsp_ch.ready <= 1'b1;
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    int p;
    int lim;
    int blk;
    int target;
    int pick;
    int reps;
    logic [15:0] blk_word;

    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = sdsq_pkg::REG_RETRY_LIMIT;
    cfg_ch.data       = 16'd0;
    card_phase   = sdsq_pkg::PH_IDLE;
    retries_used = 16'd0;
    write_addr   = 32'd0;
    retry_cap    = sdsq_pkg::RetryLimitRst;
    blk_len      = sdsq_pkg::BlockLenRst;
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // ignored events before start, failures at CMD0 and CMD8, old card, writes
    push_item(sdsq_pkg::EV_DONE, 8'hFF, 32'hFFFF_FFFF);
    push_item(sdsq_pkg::EV_WRITE, 8'h00, 32'hFFFF_FFFF);
    push_item(EV_SPARE, 8'hFF, 32'hFFFF_FFFF);
    push_item(sdsq_pkg::EV_START, 8'hFF, 32'hFFFF_FFFF);
    push_item(sdsq_pkg::EV_DONE, 8'hFF, 32'd0);
    push_item(sdsq_pkg::EV_DONE, sdsq_pkg::R1_OK, 32'd0);
    push_item(sdsq_pkg::EV_DONE, sdsq_pkg::R1_IDLE, 32'd0);
    push_item(sdsq_pkg::EV_START, 8'h00, 32'd0);
    push_item(sdsq_pkg::EV_DONE, 8'h00, 32'd0);
    push_item(sdsq_pkg::EV_DONE, sdsq_pkg::R1_IDLE, 32'd0);
    push_item(sdsq_pkg::EV_DONE, 8'h80, 32'd0);
    push_item(sdsq_pkg::EV_START, 8'h00, 32'd0);
    push_item(sdsq_pkg::EV_DONE, 8'h00, 32'd0);
    push_item(sdsq_pkg::EV_DONE, sdsq_pkg::R1_IDLE, 32'd0);
    push_item(sdsq_pkg::EV_DONE, sdsq_pkg::R1_IDLE, 32'd0);
    push_item(sdsq_pkg::EV_DONE, sdsq_pkg::R1_OLDCARD, 32'd0);
    push_item(sdsq_pkg::EV_DONE, sdsq_pkg::R1_IDLE, 32'd0);
    push_item(sdsq_pkg::EV_DONE, sdsq_pkg::R1_OK, 32'd0);
    push_item(sdsq_pkg::EV_DONE, 8'hFF, 32'd0);
    push_item(sdsq_pkg::EV_DONE, sdsq_pkg::R1_ILLEGAL, 32'd0);
    push_item(sdsq_pkg::EV_DONE, sdsq_pkg::R1_OK, 32'd0);
    push_item(sdsq_pkg::EV_WRITE, 8'hFF, 32'hFFFF_FFFF);
    push_item(sdsq_pkg::EV_DONE, sdsq_pkg::R1_OK, 32'd0);
    push_item(sdsq_pkg::EV_DONE, 8'hFF, 32'd0);
    push_item(sdsq_pkg::EV_WRITE, 8'h00, 32'd0);
    push_item(sdsq_pkg::EV_DONE, sdsq_pkg::R1_IDLE, 32'd0);
    push_item(sdsq_pkg::EV_START, 8'h00, 32'd0);
    wait_drained();

    for (p = 0; p < 12; p++) begin
      case (p % 6)
        0: lim = 0;
        1: lim = 1;
        2: lim = 65535;
        3: lim = $urandom_range(2, 6);
        4: lim = 1000;
        default: lim = $urandom_range(0, 65535);
      endcase
      case (p % 5)
        0: blk = 512;
        1: blk = 1;
        2: blk = 1023;
        3: blk = 0;
        default: blk = $urandom_range(2, 511);
      endcase
      blk_word = 16'($urandom);
      blk_word[9:0] = 10'(blk);
      write_reg(sdsq_pkg::REG_RETRY_LIMIT, 16'(lim));
      write_reg(sdsq_pkg::REG_BLOCK_LEN, blk_word);
      calm = (p % 3 == 2);
      target = issued + 155;
      while (issued < target) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) push_item(2'($urandom_range(0, 3)), 8'($urandom), $urandom);
        else if (pick < 7) begin
          reps = (lim < 8) ? $urandom_range(0, lim + 1) : $urandom_range(0, 3);
          gen_init(1'($urandom_range(0, 1)), reps);
          gen_writes($urandom_range(0, 4));
        end else gen_writes($urandom_range(1, 3));
      end
      wait_drained();
    end

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
